[hw/rtl/prt_pkg.sv]
package prt_pkg;

   // Default counter width of the timer.
   localparam int COUNTER_BITS_DEF = 16;

   // Field widths of the channels and registers.
   localparam int PRESCALE_W = 11;
   localparam int RELOAD_W   = 16;
   localparam int AMOUNT_W   = 32;
   localparam int COUNTER_W  = 16;
   localparam int OVF_W      = 32;
   localparam int LEFT_W     = 27;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Largest usable prescale value.
   localparam logic [PRESCALE_W-1:0] PRESCALE_MAX = PRESCALE_W'(1024);

   // Register indexes on the configuration channel.
   localparam logic [CSR_IDX_W-1:0] REG_PRESCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RELOAD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IRQ_EN   = 2'd2;

   // Operation codes of the request channel.
   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // Operand choice for the shared divider.
   typedef enum logic {
      DIV_OVERFLOW = 1'b0,
      DIV_COUNTER  = 1'b1
   } div_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        req_ready;
      logic        restart;
      logic        keep_sum;
      logic        div_start;
      div_sel_type div_sel;
      logic        take_ovf;
      logic        load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_valid;
      logic op_restart;
      logic period_zero;
      logic sum_ge;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

[hw/rtl/prt_if.sv]
// Request channel: one timer operation per transaction.
interface prt_req_if;
   import prt_pkg::*;
   logic                valid;
   logic                ready;
   logic                op;
   logic [AMOUNT_W-1:0] amount;
   modport source (output valid, op, amount, input ready);
   modport sink (input valid, op, amount, output ready);
endinterface

// Response channel: one result per request transaction.
interface prt_rsp_if;
   import prt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [COUNTER_W-1:0] counter;
   logic [OVF_W-1:0]     overflow_count;
   logic                 irq;
   logic [LEFT_W-1:0]    cycles_left;
   modport source (output valid, counter, overflow_count, irq, cycles_left, input ready);
   modport sink (input valid, counter, overflow_count, irq, cycles_left, output ready);
endinterface

// Register write channel.
interface prt_csr_if;
   import prt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/prt_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module prt_div #(
   parameter int DVD_W = 33,
   parameter int DVS_W = 27
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             ge;

   // One shift-and-subtract step: bring in the next dividend bit.
   always_comb begin
      trial = {rem_ff, quo_ff[DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[hw/rtl/prt_ctrl.sv]
// Sequencer for one timer operation at a time.
module prt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  prt_pkg::status_type status,
   output prt_pkg::cmd_type    cmd
);
   import prt_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOAD   = 6'b000010,
      ST_ODIV   = 6'b000100,
      ST_CSTART = 6'b001000,
      ST_CDIV   = 6'b010000,
      ST_FIN    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.op_restart) begin
               cmd.restart = 1'b1;
               state_in    = ST_CSTART;
            end else if (status.period_zero) begin
               state_in = ST_CSTART;
            end else if (status.sum_ge) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_OVERFLOW;
               state_in      = ST_ODIV;
            end else begin
               cmd.keep_sum = 1'b1;
               state_in     = ST_CSTART;
            end
         end
         ST_ODIV: begin
            if (status.div_done) begin
               cmd.take_ovf = 1'b1;
               state_in     = ST_CSTART;
            end
         end
         ST_CSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_COUNTER;
            state_in      = ST_CDIV;
         end
         ST_CDIV: begin
            if (status.div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/prt_datapath.sv]
// Timer state, configuration registers, shared divider and result register.
module prt_datapath #(
   parameter int COUNTER_BITS = prt_pkg::COUNTER_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   prt_req_if.sink             req_chan,
   prt_rsp_if.source           rsp_chan,
   prt_csr_if.sink             csr_chan,
   input  prt_pkg::cmd_type    cmd,
   output prt_pkg::status_type status
);
   import prt_pkg::*;

   localparam int ELA_W = COUNTER_BITS + 10;
   localparam int PER_W = COUNTER_BITS + 11;
   localparam int SUM_W = ((ELA_W > AMOUNT_W) ? ELA_W : AMOUNT_W) + 1;

   logic [PRESCALE_W-1:0] prescale_ff;
   logic [RELOAD_W-1:0]   reload_ff;
   logic                  irq_en_ff;
   logic                  op_ff;
   logic [AMOUNT_W-1:0]   amount_ff;
   logic [ELA_W-1:0]      elapsed_ff, elapsed_in;
   logic [PER_W-1:0]      period_ff, period_in;
   logic [OVF_W-1:0]      ovf_ff;
   logic                  ovf_flag_ff;
   logic                  rsp_valid_ff;
   logic [COUNTER_W-1:0]  rsp_counter_ff;
   logic [OVF_W-1:0]      rsp_ovf_ff;
   logic                  rsp_irq_ff;
   logic [LEFT_W-1:0]     rsp_left_ff;

   logic [PRESCALE_W-1:0]   ps_eff;
   logic [COUNTER_BITS-1:0] reload_cb;
   logic [COUNTER_BITS:0]   span;
   logic [PER_W-1:0]        product;
   logic [SUM_W-1:0]        sum;
   logic [SUM_W-1:0]        div_dividend;
   logic [PER_W-1:0]        div_divisor;
   logic                    div_done;
   logic [SUM_W-1:0]        div_quo;
   logic [PER_W-1:0]        div_rem;
   logic [COUNTER_BITS-1:0] count_cb;
   logic [PER_W-1:0]        left;

   // Register writes are always accepted.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= PRESCALE_W'(1);
         reload_ff   <= '0;
         irq_en_ff   <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_PRESCALE: prescale_ff <= csr_chan.data[PRESCALE_W-1:0];
            REG_RELOAD:   reload_ff   <= csr_chan.data[RELOAD_W-1:0];
            REG_IRQ_EN:   irq_en_ff   <= csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   // Prescale clamped to the range 1 to 1024.
   always_comb begin
      if (prescale_ff == '0) begin
         ps_eff = PRESCALE_W'(1);
      end else if (prescale_ff > PRESCALE_MAX) begin
         ps_eff = PRESCALE_MAX;
      end else begin
         ps_eff = prescale_ff;
      end
   end

   // Overflow period for a restart: prescale times the counts to wrap.
   assign reload_cb = COUNTER_BITS'(reload_ff);
   assign span      = {1'b1, {COUNTER_BITS{1'b0}}} - {1'b0, reload_cb};
   assign product   = PER_W'(ps_eff) * PER_W'(span);

   // Elapsed count after adding the requested cycles.
   assign sum = SUM_W'(elapsed_ff) + SUM_W'(amount_ff);

   // Latch the request payload when the transaction completes.
   always_ff @(posedge clock) begin
      if (req_chan.valid && cmd.req_ready) begin
         op_ff     <= req_chan.op;
         amount_ff <= req_chan.amount;
      end
   end

   // Elapsed and period state.
   always_comb begin
      elapsed_in = elapsed_ff;
      period_in  = period_ff;
      if (cmd.restart) begin
         elapsed_in = '0;
         period_in  = product;
      end else if (cmd.keep_sum) begin
         elapsed_in = ELA_W'(sum);
      end else if (cmd.take_ovf) begin
         elapsed_in = ELA_W'(div_rem);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         period_ff  <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
         period_ff  <= period_in;
      end
   end

   // Overflow count of the current transaction.
   always_ff @(posedge clock) begin
      if (req_chan.valid && cmd.req_ready) begin
         ovf_ff      <= '0;
         ovf_flag_ff <= 1'b0;
      end else if (cmd.take_ovf) begin
         ovf_ff      <= OVF_W'(div_quo);
         ovf_flag_ff <= 1'b1;
      end
   end

   // The divider serves both the overflow split and the counter read.
   always_comb begin
      case (cmd.div_sel)
         DIV_OVERFLOW: begin
            div_dividend = sum;
            div_divisor  = period_ff;
         end
         default: begin
            div_dividend = SUM_W'(elapsed_ff);
            div_divisor  = PER_W'(ps_eff);
         end
      endcase
   end

   prt_div #(
      .DVD_W(SUM_W),
      .DVS_W(PER_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Result fields from the finished state.
   assign count_cb = reload_cb + COUNTER_BITS'(div_quo);
   assign left     = period_ff - PER_W'(elapsed_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_counter_ff <= COUNTER_W'(count_cb);
         rsp_ovf_ff     <= ovf_ff;
         rsp_irq_ff     <= ovf_flag_ff && irq_en_ff;
         rsp_left_ff    <= LEFT_W'(left);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.counter        = rsp_counter_ff;
   assign rsp_chan.overflow_count = rsp_ovf_ff;
   assign rsp_chan.irq            = rsp_irq_ff;
   assign rsp_chan.cycles_left    = rsp_left_ff;

   // Status back to the controller.
   always_comb begin
      status.req_valid   = req_chan.valid;
      status.op_restart  = (op_ff == OP_RESTART);
      status.period_zero = (period_ff == '0);
      status.sum_ge      = (sum >= SUM_W'(period_ff));
      status.div_done    = div_done;
      status.out_free    = !rsp_valid_ff || rsp_chan.ready;
   end

endmodule

[hw/rtl/prescaled_reload_timer.sv]
// A restart or an advance without overflow runs the divider once, for the counter read;
// an overflowing advance first runs it to divide the sum by the period, then for that read.
// SUM_W = max(COUNTER_BITS + 10, 32) + 1 is the length of the bit-serial divider, which
// yields one quotient bit per cycle and runs once or twice per request.
// Requests: one at a time; the next is taken the cycle after the result is registered.
// Reset (synchronous, active high): elapsed and period clear, prescale 1, reload 0, no IRQ.
module prescaled_reload_timer #(
   parameter int COUNTER_BITS = prt_pkg::COUNTER_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   prt_req_if.sink   req_chan,
   prt_rsp_if.source rsp_chan,
   prt_csr_if.sink   csr_chan
);
   import prt_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign req_chan.ready = cmd.req_ready;

   prt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   prt_datapath #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .status   (status)
   );

   // A result is only loaded when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result loaded over a pending response");

   // A loaded result is presented on the response channel.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_chan.valid)
      else $error("loaded result not presented");

   // Only one request is in progress at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while busy");

   // The divider finishes only while a request is in progress.
   assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> !cmd.req_ready)
      else $error("divider finished while idle");

endmodule
